// ===== rtl/core/pbo_pkg.sv =====
// Shared types and constants for the PolyBLEP oscillator.
// Holds the controller command and status structs, the state and operation
// enums, the waveform and register codes, and the sine polynomial constants.
package pbo_pkg;

  // Phase accumulator and sine lookup resolution.
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;

  // Fixed widths of the ports and the datapath.
  localparam int CFG_W          = 32;
  localparam int WAVE_W         = 2;
  localparam int IDX_W          = 2;
  localparam int SAMPLE_W       = 16;
  localparam int ACC_W          = 19;
  localparam int BLEP_FRAC_BITS = 16;
  localparam int CNT_W          = $clog2(BLEP_FRAC_BITS);
  localparam int HORN_STEPS     = 4;

  typedef logic [PHASE_BITS-1:0] phase_t;

  // Waveform codes.
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SAW      = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_PULSE    = 2'd2;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_WAVE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_INC   = 2'd1;
  localparam logic [IDX_W-1:0] REG_PW    = 2'd2;

  // Taylor coefficients of sin(pi/2 * x) in Q30, magnitudes only.
  localparam logic [31:0] SC1 = 32'd1686629713;
  localparam logic [31:0] SC3 = 32'd693598668;
  localparam logic [31:0] SC5 = 32'd85569306;
  localparam logic [31:0] SC7 = 32'd5026994;
  localparam logic [31:0] SC9 = 32'd172273;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_BLEP_CHK,
    S_DIV,
    S_SQ_MUL,
    S_SQ_WB,
    S_X2_MUL,
    S_X2_WB,
    S_HORN_MUL,
    S_HORN_WB,
    S_S_MUL,
    S_S_WB,
    S_R_MUL,
    S_R_WB,
    S_DONE
  } state_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_BLEP,
    MUL_X2,
    MUL_HORNER,
    MUL_S,
    MUL_R
  } mul_op_t;

  // Write-back of the registered product.
  typedef enum logic [2:0] {
    WB_NONE,
    WB_BLEP,
    WB_X2,
    WB_HORNER,
    WB_S,
    WB_R
  } wb_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              blep_sel;
    logic              div_init;
    logic              div_step;
    mul_op_t           mul_op;
    wb_op_t            wb_op;
    logic              blep_neg;
    logic [1:0]        coef_idx;
    logic              advance;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic blep_hit;
  } dp_status_t;

  // Horner coefficient for each step after the first.
  function automatic logic [31:0] horner_coef(input logic [1:0] idx);
    logic [31:0] c;
    case (idx)
      2'd0:    c = SC7;
      2'd1:    c = SC5;
      2'd2:    c = SC3;
      default: c = SC1;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/polyblep_oscillator.sv =====
// Top level of the PolyBLEP band-limited oscillator: configuration registers,
// output register, and the pbo_ctrl and pbo_dpath instances.
// Depends on pbo_pkg.
//
//   Channel  Signals                             Direction  Moves
//   in       in_valid/in_ready, in_tick          input      one tick item
//   out      out_valid/out_ready, out_sample_out output     one Q1.15 sample
//   cfg      cfg_valid/cfg_ready, cfg_index/data input      one register write
//
// An item with tick set produces one sample of the selected waveform; an item
// with tick clear is taken without producing one. Each PolyBLEP edge
// correction that applies runs the 16-step restoring divider and then the
// shared multiplier. Reset is synchronous and needs no clearing pass. A result
// waits in the output register while the next item is taken; the block stalls
// only when a new result is ready and the previous one has not been taken.
module polyblep_oscillator import pbo_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_tick,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  logic [WAVE_W-1:0]          wave_r;
  logic [CFG_W-1:0]           inc_r;
  logic [CFG_W-1:0]           pw_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_free;
  logic signed [SAMPLE_W-1:0] dp_sample;
  ctrl_cmd_t                  cmd;
  dp_status_t                 status;

  assign cfg_ready      = 1'b1;
  assign out_free       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= WAVE_SAW;
      inc_r  <= '0;
      pw_r   <= {1'b1, {(CFG_W-1){1'b0}}};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WAVE: wave_r <= cfg_data[WAVE_W-1:0];
        REG_INC:  inc_r  <= cfg_data;
        REG_PW:   pw_r   <= cfg_data;
        default:  wave_r <= wave_r;
      endcase
    end
  end

  // Output register: loaded when a sample finishes, cleared when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      out_sample_r <= dp_sample;
    end
  end

  pbo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_tick  (in_tick),
    .in_ready (in_ready),
    .wave_sel (wave_r),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  pbo_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .wave_sel    (wave_r),
    .phase_inc   (inc_r),
    .pulse_width (pw_r),
    .status      (status),
    .sample      (dp_sample)
  );

  // A finished sample never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.advance && out_valid_r) |-> out_ready)
    else $error("sample overwritten before it was taken");

  // A finished sample shows on the output in the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> out_valid)
    else $error("finished sample not presented");

  // A tick item that is taken leaves the block busy, with in_ready low.
  a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_tick) |=> !in_ready)
    else $error("input taken while a tick item is in progress");

endmodule

// ===== rtl/core/pbo_ctrl.sv =====
// Sequencing state machine for the PolyBLEP oscillator.
// Depends on pbo_pkg for the state enum and the command and status structs.
// Drives the datapath one operation per cycle but waits in S_DONE for out_free; owns the step counter.
module pbo_ctrl import pbo_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_tick,
  output logic              in_ready,
  input  logic [WAVE_W-1:0] wave_sel,
  input  logic              out_free,
  input  dp_status_t        status,
  output ctrl_cmd_t         cmd
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pass_r, pass_nxt;
  logic              more_blep;

  // A pulse also needs an edge correction at the pulse-width edge.
  assign more_blep = (wave_sel == WAVE_PULSE) && !pass_r;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_tick) begin
          cnt_nxt  = '0;
          pass_nxt = 1'b0;
          case (wave_sel)
            WAVE_SINE:  state_nxt = S_X2_MUL;
            WAVE_SAW:   state_nxt = S_BLEP_CHK;
            WAVE_PULSE: state_nxt = S_BLEP_CHK;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_BLEP_CHK: begin
        if (status.blep_hit) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else if (more_blep) begin
          pass_nxt  = 1'b1;
          state_nxt = S_BLEP_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(BLEP_FRAC_BITS - 1)) begin
          state_nxt = S_SQ_MUL;
        end
      end
      S_SQ_MUL: state_nxt = S_SQ_WB;
      S_SQ_WB: begin
        if (more_blep) begin
          pass_nxt  = 1'b1;
          state_nxt = S_BLEP_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_X2_MUL: state_nxt = S_X2_WB;
      S_X2_WB: begin
        cnt_nxt   = '0;
        state_nxt = S_HORN_MUL;
      end
      S_HORN_MUL: state_nxt = S_HORN_WB;
      S_HORN_WB: begin
        if (cnt_r == CNT_W'(HORN_STEPS - 1)) begin
          state_nxt = S_S_MUL;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_HORN_MUL;
        end
      end
      S_S_MUL: state_nxt = S_S_WB;
      S_S_WB:  state_nxt = S_R_MUL;
      S_R_MUL: state_nxt = S_R_WB;
      S_R_WB:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    in_ready     = (state_r == S_IDLE);
    cmd.load     = (state_r == S_IDLE) && in_valid && in_tick;
    cmd.blep_sel = pass_r;
    cmd.div_init = (state_r == S_BLEP_CHK);
    cmd.div_step = (state_r == S_DIV);
    cmd.blep_neg = (wave_sel == WAVE_SAW) || pass_r;
    cmd.coef_idx = cnt_r[1:0];
    cmd.advance  = (state_r == S_DONE) && out_free;
    case (state_r)
      S_X2_MUL:   cmd.mul_op = MUL_X2;
      S_HORN_MUL: cmd.mul_op = MUL_HORNER;
      S_S_MUL:    cmd.mul_op = MUL_S;
      S_R_MUL:    cmd.mul_op = MUL_R;
      default:    cmd.mul_op = MUL_BLEP;
    endcase
    case (state_r)
      S_SQ_WB:   cmd.wb_op = WB_BLEP;
      S_X2_WB:   cmd.wb_op = WB_X2;
      S_HORN_WB: cmd.wb_op = WB_HORNER;
      S_S_WB:    cmd.wb_op = WB_S;
      S_R_WB:    cmd.wb_op = WB_R;
      default:   cmd.wb_op = WB_NONE;
    endcase
  end

endmodule

// ===== rtl/core/pbo_dpath.sv =====
// Arithmetic datapath for the PolyBLEP oscillator: phase accumulator,
// restoring divider, shared 32x32 multiplier and sample accumulator.
// Depends on pbo_pkg for widths, constants and the command and status structs.
module pbo_dpath import pbo_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctrl_cmd_t                  cmd,
  input  logic [WAVE_W-1:0]          wave_sel,
  input  logic [CFG_W-1:0]           phase_inc,
  input  logic [CFG_W-1:0]           pulse_width,
  output dp_status_t                 status,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam int     PH_W    = PHASE_BITS;
  localparam int     STB     = SINE_TABLE_BITS;
  localparam phase_t PH_HALF = {1'b1, {(PH_W-1){1'b0}}};
  localparam logic [PH_W:0] PH_ONE = {1'b1, {PH_W{1'b0}}};
  localparam logic [BLEP_FRAC_BITS:0] BLEP_ONE = {1'b1, {BLEP_FRAC_BITS{1'b0}}};
  localparam logic [ACC_W-1:0] HALF_SCALE = ACC_W'(32768);
  localparam logic [ACC_W-1:0] TRI_TOP    = ACC_W'(98304);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);
  localparam logic [15:0] Q15_MAX = 16'd32767;

  // Align a Q0.32 register value to the phase format.
  function automatic phase_t to_phase(input logic [31:0] v);
    logic [PH_W+31:0] w;
    w = {v, {PH_W{1'b0}}} >> 32;
    return w[PH_W-1:0];
  endfunction

  // Align a phase value to Q0.32.
  function automatic logic [31:0] to_f32(input phase_t p);
    logic [PH_W+31:0] w;
    w = {p, 32'b0} >> PH_W;
    return w[31:0];
  endfunction

  phase_t                    phase_r;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  phase_t                    rem_r;
  logic [BLEP_FRAC_BITS-1:0] quo_r;
  logic                      lo_r;
  logic [63:0]               prod_r;
  logic [31:0]               x2_r;
  logic [31:0]               a_r;

  phase_t                    dt_al, dt, pw_al, op, op_neg;
  logic [31:0]               f;
  logic [PH_W:0]             one_minus_dt, rem2, rem_sub;
  logic                      blep_lo, blep_hi, ge;
  logic [BLEP_FRAC_BITS:0]   v;
  logic [STB-1:0]            tab_i;
  logic [STB:0]              tab_k;
  logic [31:0]               x;
  logic [31:0]               mul_a, mul_b;
  logic [31:0]               prod_sh30;
  logic [63:0]               prod_rnd;
  logic [15:0]               r_raw;
  logic [14:0]               r_clip;
  logic [16:0]               tri_g;
  logic [ACC_W-1:0]          base, blep_term;

  // Increment clamp, pulse width and the waveform phase.
  always_comb begin
    dt_al = to_phase(phase_inc);
    dt    = (dt_al > PH_HALF) ? PH_HALF : dt_al;
    pw_al = to_phase(pulse_width);
    f     = to_f32(phase_r);
  end

  // Edge detection for the selected correction point.
  always_comb begin
    op           = cmd.blep_sel ? (phase_r - pw_al) : phase_r;
    op_neg       = '0 - op;
    one_minus_dt = PH_ONE - {1'b0, dt};
    blep_lo      = (op < dt);
    blep_hi      = ({1'b0, op} > one_minus_dt);
    status.blep_hit = blep_lo || blep_hi;
  end

  // One restoring division step: one quotient bit per cycle.
  always_comb begin
    rem2    = {rem_r, 1'b0};
    ge      = (rem2 >= {1'b0, dt});
    rem_sub = rem2 - {1'b0, dt};
    v       = BLEP_ONE - {1'b0, quo_r};
  end

  // Sine table index with quarter-wave mirroring.
  always_comb begin
    tab_i = f[29 -: STB];
    tab_k = f[30] ? ((STB+1)'(1 << STB) - {1'b0, tab_i}) : {1'b0, tab_i};
    x     = 32'(tab_k) << (30 - STB);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.mul_op)
      MUL_X2: begin
        mul_a = x;
        mul_b = x;
      end
      MUL_HORNER: begin
        mul_a = x2_r;
        mul_b = a_r;
      end
      MUL_S: begin
        mul_a = x;
        mul_b = a_r;
      end
      MUL_R: begin
        mul_a = a_r;
        mul_b = 32'(Q15_MAX);
      end
      default: begin
        mul_a = 32'(v);
        mul_b = 32'(v);
      end
    endcase
  end

  // Start value of each waveform before edge corrections.
  always_comb begin
    tri_g = f[31:15];
    case (wave_sel)
      WAVE_SINE:  base = '0;
      WAVE_SAW:   base = ACC_W'(f[31:16]) - HALF_SCALE;
      WAVE_PULSE: base = (phase_r < pw_al) ? HALF_SCALE : ('0 - HALF_SCALE);
      default: begin
        base = tri_g[16] ? (TRI_TOP - ACC_W'(tri_g)) : (ACC_W'(tri_g) - HALF_SCALE);
      end
    endcase
  end

  // Product write-back and accumulator update.
  always_comb begin
    prod_sh30 = prod_r[61:30];
    prod_rnd  = prod_r + 64'(1 << 29);
    r_raw     = prod_rnd[45:30];
    r_clip    = (r_raw > Q15_MAX) ? Q15_MAX[14:0] : r_raw[14:0];
    blep_term = ACC_W'(prod_r[BLEP_FRAC_BITS+17:17]);
    acc_nxt   = acc_r;
    if (cmd.load) begin
      acc_nxt = base;
    end else begin
      case (cmd.wb_op)
        WB_BLEP: begin
          acc_nxt = (lo_r ^ cmd.blep_neg) ? (acc_r - blep_term) : (acc_r + blep_term);
        end
        WB_R: begin
          acc_nxt = f[31] ? ('0 - ACC_W'(r_clip)) : ACC_W'(r_clip);
        end
        default: acc_nxt = acc_r;
      endcase
    end
  end

  // Phase accumulator: advances once per delivered sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.advance) begin
      phase_r <= phase_r + dt;
    end
  end

  // Working registers of the divider, multiplier and accumulator.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
    if (cmd.div_init) begin
      rem_r <= blep_lo ? op : op_neg;
      quo_r <= '0;
      lo_r  <= blep_lo;
    end else if (cmd.div_step) begin
      rem_r <= ge ? rem_sub[PH_W-1:0] : rem2[PH_W-1:0];
      quo_r <= {quo_r[BLEP_FRAC_BITS-2:0], ge};
    end
    case (cmd.wb_op)
      WB_X2: begin
        x2_r <= prod_sh30;
        a_r  <= SC9;
      end
      WB_HORNER: a_r <= horner_coef(cmd.coef_idx) - prod_sh30;
      WB_S:      a_r <= prod_sh30;
      default:   a_r <= a_r;
    endcase
  end

  // Saturate the accumulator to Q1.15.
  always_comb begin
    if ($signed(acc_r) > SAT_MAX) begin
      sample = SAT_MAX[SAMPLE_W-1:0];
    end else if ($signed(acc_r) < SAT_MIN) begin
      sample = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sample = acc_r[SAMPLE_W-1:0];
    end
  end

endmodule
